@@ rtl/core/chd_pkg.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Shared sizes, result codes and the classified byte record that the front
// end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package chd_pkg;

  // Width of the chunk size counter and the size accumulator.
  localparam int SIZE_BITS = 32;

  // Depth of the queue between the classifier and the decode engine.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Result codes carried on the status field.
  typedef enum logic [2:0] {
    ST_PAYLOAD   = 3'd0,
    ST_ZERO_END  = 3'd1,
    ST_MALFORMED = 3'd2,
    ST_TRUNCATED = 3'd3,
    ST_NO_TERM   = 3'd4
  } chd_status_t;

  // One input word after classification.
  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
    logic       is_hex;
    logic [3:0] hex_val;
    logic       is_space;
    logic       is_cr;
    logic       is_lf;
  } chd_item_t;

endpackage

@@ rtl/core/chd_front.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder front end
// Classifies each incoming byte: hex digit and its value, whitespace, CR, LF.
// ----------------------------------------------------------------------------
module chd_front
  import chd_pkg::*;
(
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output chd_item_t  item
);

  logic       dec_digit;
  logic       upper_hex;
  logic       lower_hex;
  logic [7:0] hex_wide;

  always_comb begin
    dec_digit = (data_byte >= 8'h30) && (data_byte <= 8'h39);
    upper_hex = (data_byte >= 8'h41) && (data_byte <= 8'h46);
    lower_hex = (data_byte >= 8'h61) && (data_byte <= 8'h66);

    if (dec_digit) begin
      hex_wide = data_byte - 8'h30;
    end else if (upper_hex) begin
      hex_wide = data_byte - 8'h37;
    end else if (lower_hex) begin
      hex_wide = data_byte - 8'h57;
    end else begin
      hex_wide = 8'h00;
    end

    item.byte_val = data_byte;
    item.last     = last_byte;
    item.is_hex   = dec_digit || upper_hex || lower_hex;
    item.hex_val  = hex_wide[3:0];
    // Space, TAB, LF, VT, FF and CR all count as whitespace.
    item.is_space = (data_byte == 8'h20) || ((data_byte >= 8'h09) && (data_byte <= 8'h0D));
    item.is_cr    = (data_byte == 8'h0D);
    item.is_lf    = (data_byte == 8'h0A);
  end

endmodule

@@ rtl/core/chd_queue.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder queue
// Small register FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module chd_queue
  import chd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push_valid,
  output logic      push_ready,
  input  chd_item_t push_item,
  output logic      pop_valid,
  input  logic      pop_ready,
  output chd_item_t pop_item
);

  chd_item_t               slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]    wr_ptr;
  logic [QPTR_BITS-1:0]    rd_ptr;
  logic [QCNT_BITS-1:0]    count;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready = (count != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= push_item;
        if (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
          wr_ptr <= '0;
        end else begin
          wr_ptr <= wr_ptr + 1'b1;
        end
      end
      if (do_pop) begin
        if (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) begin
          rd_ptr <= '0;
        end else begin
          rd_ptr <= rd_ptr + 1'b1;
        end
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/chd_back.sv @@
// ----------------------------------------------------------------------------
// Chunked body decoder back end
// Runs the size line, data and trailer state machine on classified bytes and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module chd_back
  import chd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       pop_valid,
  output logic       pop_ready,
  input  chd_item_t  item,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic [2:0] m_tuser,
  output logic       m_tlast
);

  typedef enum logic [1:0] {
    PH_SIZE  = 2'd0,
    PH_DATA  = 2'd1,
    PH_TRAIL = 2'd2,
    PH_STOP  = 2'd3
  } phase_t;

  phase_t                 phase, phase_next;
  logic [SIZE_BITS-1:0]   chunk_rem, chunk_rem_next;
  logic [SIZE_BITS-1:0]   size_acc, size_acc_next;
  logic                   digits_seen, digits_seen_next;
  logic                   digits_closed, digits_closed_next;
  logic                   cr_pending, cr_pending_next;

  logic                   step;
  logic                   do_size;
  logic                   clr;
  logic                   lf_handled;
  logic                   malformed;
  logic                   zero_end;
  logic                   res_valid;
  logic [7:0]             res_payload;
  chd_status_t            res_status;
  logic                   res_done;

  // The engine takes a byte whenever the output register is free or drains.
  assign pop_ready = !m_tvalid || m_tready;
  assign step      = pop_valid && pop_ready;

  always_comb begin
    phase_next         = phase;
    chunk_rem_next     = chunk_rem;
    size_acc_next      = size_acc;
    digits_seen_next   = digits_seen;
    digits_closed_next = digits_closed;
    cr_pending_next    = cr_pending;
    res_valid          = 1'b0;
    res_payload        = 8'h00;
    res_status         = ST_PAYLOAD;
    res_done           = 1'b0;
    do_size            = 1'b0;
    clr                = 1'b0;
    lf_handled         = 1'b0;
    malformed          = 1'b0;
    zero_end           = 1'b0;

    unique case (phase)
      PH_DATA: begin
        res_valid      = 1'b1;
        res_payload    = item.byte_val;
        chunk_rem_next = chunk_rem - SIZE_BITS'(1);
        if (chunk_rem <= SIZE_BITS'(1)) begin
          chunk_rem_next  = '0;
          phase_next      = PH_TRAIL;
          cr_pending_next = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (cr_pending) begin
          phase_next = PH_SIZE;
          clr        = 1'b1;
          // A CR not followed by LF leaves this byte to the next size line.
          do_size    = !item.is_lf;
        end else if (item.is_cr) begin
          cr_pending_next = 1'b1;
        end else begin
          phase_next = PH_SIZE;
          clr        = 1'b1;
          do_size    = 1'b1;
        end
      end
      PH_SIZE: begin
        do_size = 1'b1;
      end
      PH_STOP: begin
      end
      default: begin
      end
    endcase

    if (clr) begin
      size_acc_next      = '0;
      digits_seen_next   = 1'b0;
      digits_closed_next = 1'b0;
      cr_pending_next    = 1'b0;
    end

    if (do_size) begin
      if (cr_pending_next) begin
        cr_pending_next = 1'b0;
        if (item.is_lf) begin
          lf_handled = 1'b1;
          if (!digits_seen_next) begin
            malformed = 1'b1;
          end else if (size_acc_next == '0) begin
            zero_end = 1'b1;
          end else begin
            chunk_rem_next     = size_acc_next;
            phase_next         = PH_DATA;
            size_acc_next      = '0;
            digits_seen_next   = 1'b0;
            digits_closed_next = 1'b0;
          end
        end
      end
      if (!lf_handled) begin
        if (item.is_cr) begin
          cr_pending_next = 1'b1;
          if (digits_seen_next) begin
            digits_closed_next = 1'b1;
          end
        end else if (!digits_closed_next) begin
          if (item.is_hex) begin
            // A digit that would push the size past its width is an error.
            if (size_acc_next[SIZE_BITS-1 -: 4] != 4'h0) begin
              malformed = 1'b1;
            end else begin
              size_acc_next    = {size_acc_next[SIZE_BITS-5:0], item.hex_val};
              digits_seen_next = 1'b1;
            end
          end else if (digits_seen_next) begin
            digits_closed_next = 1'b1;
          end else if (!item.is_space) begin
            malformed = 1'b1;
          end
        end
      end
    end

    if (malformed || zero_end) begin
      phase_next         = PH_STOP;
      size_acc_next      = '0;
      digits_seen_next   = 1'b0;
      digits_closed_next = 1'b0;
      cr_pending_next    = 1'b0;
      res_valid          = 1'b1;
      res_payload        = 8'h00;
      res_status         = malformed ? ST_MALFORMED : ST_ZERO_END;
      res_done           = 1'b1;
    end

    if (item.last) begin
      if (!(res_valid && res_done) && (phase != PH_STOP)) begin
        res_valid   = 1'b1;
        res_done    = 1'b1;
        res_payload = (phase == PH_DATA) ? item.byte_val : 8'h00;
        if ((phase_next == PH_DATA) && (chunk_rem_next != '0)) begin
          res_status = ST_TRUNCATED;
        end else begin
          res_status = ST_NO_TERM;
        end
      end
      phase_next         = PH_SIZE;
      chunk_rem_next     = '0;
      size_acc_next      = '0;
      digits_seen_next   = 1'b0;
      digits_closed_next = 1'b0;
      cr_pending_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      chunk_rem     <= '0;
      size_acc      <= '0;
      digits_seen   <= 1'b0;
      digits_closed <= 1'b0;
      cr_pending    <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (step) begin
        phase         <= phase_next;
        chunk_rem     <= chunk_rem_next;
        size_acc      <= size_acc_next;
        digits_seen   <= digits_seen_next;
        digits_closed <= digits_closed_next;
        cr_pending    <= cr_pending_next;
        m_tvalid      <= res_valid;
        if (res_valid) begin
          m_tdata <= res_payload;
          m_tuser <= res_status;
          m_tlast <= res_done;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // Inside a chunk there is always at least one data byte still due.
  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (chunk_rem != '0))
    else $error("data phase with no bytes remaining");

  // Only payload words leave the stream open, every other code ends it.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tuser == ST_PAYLOAD) != m_tlast))
    else $error("status and end flag disagree");

  // A final input byte always returns the engine to a clean size line.
  assert property (@(posedge clk) disable iff (rst)
    (step && item.last) |=> ((phase == PH_SIZE) && !cr_pending && !digits_seen
                             && (size_acc == '0)))
    else $error("engine not reset after final byte");

  // A stopped stream produces no words until the final byte arrives.
  assert property (@(posedge clk) disable iff (rst)
    (step && (phase == PH_STOP)) |=> (m_tvalid == $past(m_tvalid && !m_tready)))
    else $error("word produced while stopped");
`endif

endmodule

@@ rtl/core/http_chunked_body_decoder.sv @@
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Turns a chunked transfer body, one byte per word, into its payload bytes.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries the raw body, one byte per word, with tlast set on
// the final byte of the body. The master stream carries one word per payload
// byte and one closing word per body: tuser gives the status (payload, zero
// chunk end, malformed size, truncated chunk, or ended without terminator) and
// tlast marks the word that ends the decoded stream. Size lines, chunk CR LF
// and anything after an end are consumed without producing words.
// A classifier tags each accepted byte, a two-word queue buffers it, and the
// decode engine runs one byte per cycle into a registered output while that
// register is free or draining. A result passes a queue slot and then the
// output register, and the block sustains one byte per cycle when not stalled.
// When the master side stalls, the output register holds its word and the
// queue absorbs up to two more bytes before s_tready drops.
// Synchronous reset returns the engine to the start of a size line and
// empties the queue and the output register. Every byte flagged with tlast
// also returns the engine to that start state after it is handled.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
  import chd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tlast,   // last_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] payload_byte
  output logic [2:0] m_tuser,   // [2:0] status
  output logic       m_tlast    // stream_done
);

  chd_item_t front_item;
  chd_item_t head_item;
  logic      head_valid;
  logic      head_ready;

  // Byte classification ahead of the queue.
  chd_front u_front (
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .item      (front_item)
  );

  // Decouples input acceptance from output stalls.
  chd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (s_tvalid),
    .push_ready (s_tready),
    .push_item  (front_item),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_item   (head_item)
  );

  // Size line, data and trailer parsing with the output register.
  chd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (head_valid),
    .pop_ready (head_ready),
    .item      (head_item),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the HTTP chunked body decoder
// Drives chunked bodies into the byte stream: directed corner cases,
// well-formed bodies with random content, broken size lines and raw noise.
// Random idle cycles are inserted on both sides, and one long stall on the
// output side backs the block up. A behavioral decoder in the bench predicts
// every output word, and each word is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import chd_pkg::*;

  localparam int          ITEM_TARGET  = 1250;
  localparam int          LIMIT_CYCLES = 200000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          IDLE_PCT     = 36;
  localparam int          PRINT_CAP    = 30;
  localparam logic [7:0]  CH_CR        = 8'h0D;
  localparam logic [7:0]  CH_LF        = 8'h0A;

  typedef enum logic [1:0] {PH_SIZE, PH_DATA, PH_TRAIL, PH_STOP} dec_phase_t;

  typedef struct packed {
    logic [7:0]  pay;
    chd_status_t status;
    logic        done;
  } dec_word_t;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'd0;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [2:0] m_tuser;
  logic       m_tlast;

  http_chunked_body_decoder DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Decoder state mirrored by the bench.
  dec_phase_t           dec_phase;
  logic [SIZE_BITS-1:0] chunk_left;
  logic [SIZE_BITS-1:0] size_acc;
  bit                   have_digit;
  bit                   num_closed;
  bit                   saw_cr;

  dec_word_t  expected_words[$];
  logic [7:0] body_bytes[$];
  int         mismatches    = 0;
  int         bytes_sent    = 0;
  int         cycles        = 0;
  bit         tx_steady     = 0;
  bit         rx_steady     = 0;
  int         hold_requests = 0;
  int         holds_served  = 0;
  int         hold_left     = 0;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void clear_line();
    size_acc   = '0;
    have_digit = 0;
    num_closed = 0;
    saw_cr     = 0;
  endfunction

  function automatic void reset_decoder();
    dec_phase  = PH_SIZE;
    chunk_left = '0;
    clear_line();
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    return -1;
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Stops the decoder with a closing word.
  function automatic bit stop_with(input chd_status_t st, output dec_word_t w);
    dec_phase = PH_STOP;
    clear_line();
    w = '{8'd0, st, 1'b1};
    return 1;
  endfunction

  // One byte of a size line; returns 1 when it yields a word.
  function automatic bit size_line_byte(input logic [7:0] c, output dec_word_t w);
    int dig;
    w = '0;
    if (saw_cr) begin
      saw_cr = 0;
      if (c == CH_LF) begin
        if (!have_digit) return stop_with(ST_MALFORMED, w);
        if (size_acc == 0) return stop_with(ST_ZERO_END, w);
        chunk_left = size_acc;
        dec_phase  = PH_DATA;
        clear_line();
        return 0;
      end
    end
    if (c == CH_CR) begin
      saw_cr = 1;
      if (have_digit) num_closed = 1;
      return 0;
    end
    if (num_closed) return 0;
    dig = hex_digit(c);
    if (dig >= 0) begin
      // A nonzero top nibble means one more digit would overflow the size.
      if (size_acc[SIZE_BITS-1 -: 4] != 0) return stop_with(ST_MALFORMED, w);
      size_acc   = {size_acc[SIZE_BITS-5:0], dig[3:0]};
      have_digit = 1;
      return 0;
    end
    if (have_digit) begin
      num_closed = 1;
      return 0;
    end
    if (is_blank(c)) return 0;
    return stop_with(ST_MALFORMED, w);
  endfunction

  // Consumes one accepted input word and queues the word it should produce.
  function automatic void decode_byte(input logic [7:0] c, input logic is_last);
    dec_phase_t entry    = dec_phase;
    bit         was_data = 0;
    bit         got      = 0;
    dec_word_t  w        = '0;
    case (dec_phase)
      PH_DATA: begin
        was_data = 1;
        got      = 1;
        w        = '{c, ST_PAYLOAD, 1'b0};
        if (chunk_left != 0) chunk_left = chunk_left - 1;
        if (chunk_left == 0) begin
          dec_phase = PH_TRAIL;
          saw_cr    = 0;
        end
      end
      PH_TRAIL: begin
        if (saw_cr) begin
          // CR LF after data is dropped; a lone CR is leading blank space.
          dec_phase = PH_SIZE;
          clear_line();
          if (c != CH_LF) got = size_line_byte(c, w);
        end else if (c == CH_CR) begin
          saw_cr = 1;
        end else begin
          dec_phase = PH_SIZE;
          clear_line();
          got = size_line_byte(c, w);
        end
      end
      PH_SIZE: got = size_line_byte(c, w);
      default: ;
    endcase
    if (is_last) begin
      if (!(got && w.done) && entry != PH_STOP) begin
        w.pay  = was_data ? c : 8'd0;
        w.done = 1'b1;
        if (dec_phase == PH_DATA && chunk_left != 0) w.status = ST_TRUNCATED;
        else w.status = ST_NO_TERM;
        got = 1;
      end
      reset_decoder();
    end
    if (got) expected_words.push_back(w);
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Output words are checked before the input word of the same edge is
  // predicted, since a result always trails its byte through the queue and the output register.
  always @(posedge clk) begin : check_words
    dec_word_t w;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected word data=%02h status=%0d done=%0b",
                                    m_tdata, m_tuser, m_tlast));
        end else begin
          w = expected_words.pop_front();
          if (m_tdata !== w.pay)
            report_mismatch($sformatf("payload %02h, predicted %02h", m_tdata, w.pay));
          if (m_tuser !== w.status)
            report_mismatch($sformatf("status %0d, predicted %0d", m_tuser, w.status));
          if (m_tlast !== w.done)
            report_mismatch($sformatf("stream_done %0b, predicted %0b", m_tlast, w.done));
        end
      end
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
    end
  end

  // Output side: random stalls, plus a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= rx_steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("http_chunked_body_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Offers one word and waits for it to be taken; valid stays high afterwards
  // so back-to-back words need no second assignment in the same step.
  task automatic send_byte(input logic [7:0] c, input logic is_last);
    while (!tx_steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= is_last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic add_text(input string t);
    for (int i = 0; i < t.len(); i++) body_bytes.push_back(t[i]);
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 10) return 8'h30 + nib;
    return (upper ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic add_hex(input logic [63:0] v, input bit upper);
    logic [7:0] rev[$];
    do begin
      rev.push_front(hex_char(v[3:0], upper));
      v = v >> 4;
    end while (v != 0);
    foreach (rev[i]) body_bytes.push_back(rev[i]);
  endtask

  // One chunk with random blank space, case, leading zeros and extension.
  task automatic add_chunk(input int size);
    case ($urandom_range(9))
      0: add_text(" ");
      1: add_text("\t ");
      default: ;
    endcase
    if ($urandom_range(7) == 0) add_text("0");
    add_hex(64'(size), 1'($urandom_range(1)));
    case ($urandom_range(7))
      0: add_text(";name=val");
      1: add_text(" ;x");
      2: add_text("\t");
      default: ;
    endcase
    add_text("\r\n");
    repeat (size) body_bytes.push_back(8'($urandom_range(255)));
    // The CR LF after data is optional; a lone CR counts as blank space.
    case ($urandom_range(9))
      0: ;
      1: add_text("\r");
      default: add_text("\r\n");
    endcase
  endtask

  function automatic int pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 2) return $urandom_range(100, 300);
    if (r < 15) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  task automatic build_good_body();
    repeat ($urandom_range(1, 4)) add_chunk(pick_size());
    case ($urandom_range(7))
      0: add_text("0\r\n");
      1: add_text("0;end\r\nTrailer: x\r\n\r\n");
      2: ;
      default: add_text("0\r\n\r\n");
    endcase
  endtask

  // Sends the first n buffered bytes, the last of them flagged, and clears
  // the buffer. A short n cuts the body off anywhere.
  task automatic send_body(input int n);
    for (int i = 0; i < n; i++) send_byte(body_bytes[i], i == n - 1);
    body_bytes.delete();
  endtask

  task automatic send_maybe_cut();
    if ($urandom_range(3) == 0) send_body($urandom_range(1, body_bytes.size()));
    else send_body(body_bytes.size());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed_cases();
    // Single 0xFF payload byte, then a clean zero chunk.
    add_text("1\r\n");
    body_bytes.push_back(8'hFF);
    add_text("\r\n0\r\n");
    send_body(body_bytes.size());
    // Bad byte before any digit.
    add_text(";");
    send_body(body_bytes.size());
    // Empty size line.
    add_text("\r\n");
    send_body(body_bytes.size());
    // Body cut inside a chunk, last byte is a 0x00 payload byte.
    add_text("2\r\n");
    body_bytes.push_back(8'h00);
    send_body(body_bytes.size());
    // Ninth significant digit overflows the size.
    add_text("123456789");
    send_body(body_bytes.size());
  endtask

  task automatic test_well_formed_bodies(input int count);
    repeat (count) begin
      build_good_body();
      send_maybe_cut();
    end
  endtask

  // A broken or unusual opening, then a normal body that is either decoded
  // or ignored while the block is stopped.
  task automatic test_malformed_bodies(input int count);
    repeat (count) begin
      case ($urandom_range(10))
        0: add_text("0x1A\r\n");
        1: add_text(";ext\r\n");
        2: add_text("-4\r\n");
        3: add_text("\r\n");
        4: add_hex({28'd0, 4'($urandom_range(1, 15)), 32'($urandom)},
                   1'($urandom_range(1)));
        5: add_text("000000001\r\nQ\r\n");
        6: add_hex(64'hFFFF_FFFF, 1'($urandom_range(1)));
        7: add_text("\n \t3 \r\nxyz\r\n");
        8: add_text("2\r\nhi");
        9: add_text("3\r;\r\nabc\r\n");
        default: add_text("\rA\r\n0123456789\r\n");
      endcase
      if ($urandom_range(1)) add_text("\r\n");
      build_good_body();
      send_maybe_cut();
    end
  endtask

  // Raw bytes, half of them drawn from the characters the parser cares about.
  task automatic test_byte_noise(input int count);
    string specials;
    logic [7:0] c;
    specials = "\r\n\r\n 0;9aFx\t-";
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(1)) c = specials[$urandom_range(specials.len() - 1)];
      else c = 8'($urandom_range(255));
      send_byte(c, i == count - 1 || $urandom_range(15) == 0);
    end
  endtask

  // The output side holds off long enough for the queue to fill and the
  // input side to stall, while words keep being offered.
  task automatic test_output_backpressure();
    tx_steady = 1;
    hold_requests++;
    add_chunk(20);
    add_chunk(20);
    add_text("0\r\n\r\n");
    send_body(body_bytes.size());
    tx_steady = 0;
  endtask

  task automatic test_full_rate();
    tx_steady = 1;
    rx_steady = 1;
    test_well_formed_bodies(6);
    tx_steady = 0;
    rx_steady = 0;
  endtask

  task automatic test_random_mix();
    while (bytes_sent < ITEM_TARGET) begin
      case ($urandom_range(9))
        7, 8: test_malformed_bodies(1);
        9: test_byte_noise($urandom_range(4, 24));
        default: test_well_formed_bodies(1);
      endcase
    end
  endtask

  initial begin
    reset_decoder();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_well_formed_bodies(8);
    test_malformed_bodies(12);
    test_byte_noise(40);
    test_output_backpressure();
    test_full_rate();
    test_random_mix();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0)
      report_mismatch($sformatf("%0d predicted words never arrived", expected_words.size()));
    if (mismatches == 0) $display("http_chunked_body_decoder: match");
    else $display("http_chunked_body_decoder: mismatch");
    $finish;
  end

endmodule
